// ===== rtl/blti_pkg.sv =====
// Shared types and constants for the brightness-to-luminance interpolator.
// Depends on nothing; the core, tables, divider and sequencer import it.
`timescale 1ns / 1ps
package blti_pkg;

  localparam int VW        = 16;
  localparam int BRT_IW    = 8;
  localparam int STEP_IW   = 9;
  localparam int HUND_W    = 23;
  localparam int BRT_DEPTH  = 256;
  localparam int STEP_DEPTH = 512;
  localparam logic [HUND_W-1:0] HUND_MAX = 23'h7FFFFF;

  typedef enum logic [1:0] {
    KIND_WR_BRT  = 2'd0,
    KIND_WR_LUM  = 2'd1,
    KIND_WR_STEP = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_BRT_CNT0  = 2'd0,
    REG_BRT_CNT1  = 2'd1,
    REG_STEP_CNT0 = 2'd2,
    REG_STEP_CNT1 = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [8:0] brt_cnt0;
    logic [8:0] brt_cnt1;
    logic [9:0] step_cnt0;
    logic [9:0] step_cnt1;
  } cfg_t;

  typedef struct packed {
    logic          we_brt;
    logic          we_lum;
    logic          we_step;
    logic          wr_sd;
    logic [8:0]    wr_idx;
    logic [VW-1:0] wr_data;
    logic          rd_sd;
    logic [8:0]    rd_idx;
  } mem_req_t;

  typedef struct packed {
    logic [VW-1:0] brt;
    logic [VW-1:0] lum;
    logic [VW-1:0] step;
  } mem_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [9:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic busy;
    logic dividing;
  } ctrl_stat_t;

endpackage

// ===== rtl/blti_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
// Depends on nothing.
`timescale 1ns / 1ps
interface blti_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        subdev;
  logic [8:0]  entry_index;
  logic [15:0] entry_value;
  logic [15:0] brightness;
  modport source (output valid, kind, subdev, entry_index, entry_value, brightness,
                  input ready);
  modport sink (input valid, kind, subdev, entry_index, entry_value, brightness,
                output ready);
endinterface

interface blti_out_if;
  logic        valid;
  logic        ready;
  logic        error;
  logic [7:0]  lum_index;
  logic [8:0]  pac_step;
  logic [15:0] luminance;
  logic [22:0] luminance_hundredths;
  modport source (output valid, error, lum_index, pac_step, luminance,
                  luminance_hundredths, input ready);
  modport sink (input valid, error, lum_index, pac_step, luminance,
                luminance_hundredths, output ready);
endinterface

interface blti_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/brightness_to_luminance_interpolator_core.sv =====
// Top level of the brightness-to-luminance interpolator: configuration
// registers, tables, sequencer and divider. Uses blti_pkg and blti_if.
`timescale 1ns / 1ps
// A write transaction stores at most one table word. A query transaction runs
// four binary searches one after another over single-read-port table memories
// (set-up reads of the last and first entries, then a probe and a compare per
// probe, up to nine probes in the brightness table and ten in the step
// table), reads of the lower and upper entries, two multiply stages and a
// one-bit-per-cycle divider that holds the sequencer until it is done. With
// equal steps the divider is skipped, and a failed range check ends the query
// early. One item is in work at a time; a finished result waits in the output
// register while the next transaction is taken, and a result that cannot
// leave holds the sequencer in its last state. No clearing pass: tables are
// undefined until written.
module brightness_to_luminance_interpolator_core (
  input  logic        clk,
  input  logic        rst_n,
  blti_in_if.sink     in_ch,
  blti_out_if.source  out_ch,
  blti_cfg_if.sink    cfg_ch
);
  import blti_pkg::*;

  cfg_t       cfg_r;
  mem_req_t   mreq;
  mem_rsp_t   mrsp;
  div_req_t   dreq;
  div_rsp_t   drsp;
  ctrl_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_BRT_CNT0:  cfg_r.brt_cnt0  <= cfg_ch.data[8:0];
        REG_BRT_CNT1:  cfg_r.brt_cnt1  <= cfg_ch.data[8:0];
        REG_STEP_CNT0: cfg_r.step_cnt0 <= cfg_ch.data;
        REG_STEP_CNT1: cfg_r.step_cnt1 <= cfg_ch.data;
      endcase
    end
  end

  blti_tables u_tables (
    .clk (clk),
    .req (mreq),
    .rsp (mrsp)
  );

  blti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  blti_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .mreq   (mreq),
    .mrsp   (mrsp),
    .dreq   (dreq),
    .drsp   (drsp),
    .stat   (stat)
  );

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error |-> (out_ch.lum_index == 8'd0) &&
      (out_ch.pac_step == 9'd0) && (out_ch.luminance == 16'd0) &&
      (out_ch.luminance_hundredths == 23'd0))
    else $error("error result carries a payload");

  a_div_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    stat.dividing |-> !in_ch.ready)
    else $error("input taken during division");

  a_result_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(stat.busy))
    else $error("result without a query in work");
`endif

endmodule

// ===== rtl/blti_tables.sv =====
// Brightness, luminance and step tables of both sub-panels, one synchronous
// memory each with one write and one registered read port. Uses blti_pkg.
`timescale 1ns / 1ps
module blti_tables (
  input  logic               clk,
  input  blti_pkg::mem_req_t req,
  output blti_pkg::mem_rsp_t rsp
);
  import blti_pkg::*;

  logic [VW-1:0] brt_mem  [2*BRT_DEPTH];
  logic [VW-1:0] lum_mem  [2*BRT_DEPTH];
  logic [VW-1:0] step_mem [2*STEP_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we_brt) begin
      brt_mem[{req.wr_sd, req.wr_idx[BRT_IW-1:0]}] <= req.wr_data;
    end
    if (req.we_lum) begin
      lum_mem[{req.wr_sd, req.wr_idx[BRT_IW-1:0]}] <= req.wr_data;
    end
    if (req.we_step) begin
      step_mem[{req.wr_sd, req.wr_idx[STEP_IW-1:0]}] <= req.wr_data;
    end
    rsp.brt  <= brt_mem[{req.rd_sd, req.rd_idx[BRT_IW-1:0]}];
    rsp.lum  <= lum_mem[{req.rd_sd, req.rd_idx[BRT_IW-1:0]}];
    rsp.step <= step_mem[{req.rd_sd, req.rd_idx[STEP_IW-1:0]}];
  end

endmodule

// ===== rtl/blti_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 10-bit
// divisor, unsigned. Uses blti_pkg.
`timescale 1ns / 1ps
module blti_div (
  input  logic               clk,
  input  logic               rst_n,
  input  blti_pkg::div_req_t req,
  output blti_pkg::div_rsp_t rsp
);
  import blti_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [9:0]  rem_r;
  logic [9:0]  den_r;
  logic [31:0] quo_r;
  logic [10:0] trial_c;
  logic        fit_c;
  logic [10:0] diff_c;

  assign trial_c = {rem_r, quo_r[31]};
  assign fit_c   = trial_c >= {1'b0, den_r};
  assign diff_c  = trial_c - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
        rem_r  <= '0;
        den_r  <= req.den;
        quo_r  <= req.num;
      end else if (busy_r) begin
        rem_r <= fit_c ? diff_c[9:0] : trial_c[9:0];
        quo_r <= {quo_r[30:0], fit_c};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== rtl/blti_ctrl.sv =====
// Table writes, query sequencer: binary searches, interpolation arithmetic
// and the result register. Uses blti_pkg and the channel interfaces.
`timescale 1ns / 1ps
module blti_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  blti_pkg::cfg_t       cfg,
  blti_in_if.sink              in_ch,
  blti_out_if.source           out_ch,
  output blti_pkg::mem_req_t   mreq,
  input  blti_pkg::mem_rsp_t   mrsp,
  output blti_pkg::div_req_t   dreq,
  input  blti_pkg::div_rsp_t   drsp,
  output blti_pkg::ctrl_stat_t stat
);
  import blti_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SR_LAST, ST_SR_FIRST, ST_SR_INIT, ST_SR_PROBE, ST_SR_CMP,
    ST_RD_LO, ST_RD_UP, ST_RD_UP2, ST_MUL1, ST_MUL2, ST_DIV_GO, ST_DIV_WAIT,
    ST_SUM, ST_FIN
  } state_t;

  typedef enum logic [1:0] {PH_BRT, PH_SLO, PH_SQ, PH_SUP} phase_t;

  state_t        state_r;
  phase_t        ph_r;
  logic          tbl_step_r;
  logic          sd_r;
  logic          err_r;
  logic [VW-1:0] b_r, v_r, last_brt_r, blo_r, bup_r, lumlo_r, lumup_r;
  logic [9:0]    n_r, ns_r, l_r, hi_r;
  logic [8:0]    m_r, slo_r, sq_r, sup_r;
  logic [7:0]    up_r, lo_r;
  logic signed [27:0] p1_r;
  logic signed [34:0] p2_r;
  logic          neg_r;
  logic signed [32:0] q_r;
  logic [HUND_W-1:0]  hund_r;

  logic              out_valid_r, out_err_r;
  logic [7:0]        out_idx_r;
  logic [8:0]        out_step_r;
  logic [VW-1:0]     out_lum_r;
  logic [HUND_W-1:0] out_hund_r;

  logic          accept_c;
  logic [VW-1:0] rd_data_c;
  logic [9:0]    m_c;
  logic [8:0]    idx_c;
  logic          found_c;
  logic [8:0]    found_idx_c;
  logic [8:0]    brt_cnt_c;
  logic [9:0]    step_cnt_c, nb_c, ns_c;
  logic signed [16:0] diff_c;
  logic signed [10:0] ds_c, den_c;
  logic signed [27:0] prod_c;
  logic signed [34:0] p2_c, p2_abs_c;
  logic signed [10:0] den_abs_c;
  logic signed [32:0] q_c;
  logic [HUND_W-1:0]  base_c;
  logic signed [34:0] sum_c;
  logic [HUND_W-1:0]  clamp_c;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept_c    = in_ch.valid && in_ch.ready;

  assign brt_cnt_c  = in_ch.subdev ? cfg.brt_cnt1 : cfg.brt_cnt0;
  assign step_cnt_c = in_ch.subdev ? cfg.step_cnt1 : cfg.step_cnt0;
  assign nb_c = (brt_cnt_c > 9'(BRT_DEPTH)) ? 10'(BRT_DEPTH) : {1'b0, brt_cnt_c};
  assign ns_c = (step_cnt_c > 10'(STEP_DEPTH)) ? 10'(STEP_DEPTH) : step_cnt_c;

  assign rd_data_c = tbl_step_r ? mrsp.step : mrsp.brt;
  assign m_c       = l_r + ((hi_r - l_r - 10'd1) >> 1);

  always_comb begin
    unique case (state_r)
      ST_SR_LAST:  idx_c = 9'(n_r - 10'd1);
      ST_SR_PROBE: idx_c = m_c[8:0];
      ST_RD_LO:    idx_c = {1'b0, lo_r};
      ST_RD_UP:    idx_c = {1'b0, up_r};
      default:     idx_c = '0;
    endcase
  end

  assign found_c = ((state_r == ST_SR_PROBE) && (l_r >= hi_r) && (l_r != n_r)) ||
                   ((state_r == ST_SR_CMP) && (rd_data_c == v_r));
  assign found_idx_c = (state_r == ST_SR_CMP) ? m_r : l_r[8:0];

  assign mreq.we_brt  = accept_c && (in_ch.kind == KIND_WR_BRT) && !in_ch.entry_index[8];
  assign mreq.we_lum  = accept_c && (in_ch.kind == KIND_WR_LUM) && !in_ch.entry_index[8];
  assign mreq.we_step = accept_c && (in_ch.kind == KIND_WR_STEP);
  assign mreq.wr_sd   = in_ch.subdev;
  assign mreq.wr_idx  = in_ch.entry_index;
  assign mreq.wr_data = in_ch.entry_value;
  assign mreq.rd_sd   = sd_r;
  assign mreq.rd_idx  = idx_c;

  assign diff_c    = $signed({1'b0, lumup_r}) - $signed({1'b0, lumlo_r});
  assign ds_c      = $signed({2'b00, sq_r}) - $signed({2'b00, slo_r});
  assign den_c     = $signed({2'b00, sup_r}) - $signed({2'b00, slo_r});
  assign prod_c    = diff_c * ds_c;
  assign p2_c      = 35'(p1_r) * 35'sd100;
  assign p2_abs_c  = p2_r[34] ? -p2_r : p2_r;
  assign den_abs_c = den_c[10] ? -den_c : den_c;
  assign q_c       = neg_r ? -$signed({1'b0, drsp.quo}) : $signed({1'b0, drsp.quo});
  assign base_c    = lumlo_r * 23'd100;
  assign sum_c     = $signed({12'd0, base_c}) + 35'(q_r);

  always_comb begin
    priority if (sum_c < 35'sd0) begin
      clamp_c = '0;
    end else if (sum_c > 35'sd8388607) begin
      clamp_c = HUND_MAX;
    end else begin
      clamp_c = sum_c[HUND_W-1:0];
    end
  end

  assign dreq.start = (state_r == ST_DIV_GO);
  assign dreq.num   = p2_abs_c[31:0];
  assign dreq.den   = den_abs_c[9:0];

  assign stat.busy     = (state_r != ST_IDLE);
  assign stat.dividing = drsp.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      if (found_c) begin
        unique case (ph_r)
          PH_BRT: begin
            up_r    <= found_idx_c[7:0];
            lo_r    <= (found_idx_c == 9'd0) ? 8'd0 : 8'(found_idx_c - 9'd1);
            state_r <= ST_RD_LO;
          end
          PH_SLO: begin
            slo_r   <= found_idx_c;
            v_r     <= b_r;
            ph_r    <= PH_SQ;
            state_r <= ST_SR_LAST;
          end
          PH_SQ: begin
            sq_r    <= found_idx_c;
            v_r     <= bup_r;
            ph_r    <= PH_SUP;
            state_r <= ST_SR_LAST;
          end
          PH_SUP: begin
            sup_r   <= found_idx_c;
            state_r <= ST_MUL1;
          end
        endcase
      end else begin
        unique case (state_r)
          ST_IDLE: begin
            if (accept_c && (in_ch.kind == KIND_QUERY)) begin
              sd_r       <= in_ch.subdev;
              b_r        <= in_ch.brightness;
              v_r        <= in_ch.brightness;
              n_r        <= nb_c;
              ns_r       <= ns_c;
              tbl_step_r <= 1'b0;
              ph_r       <= PH_BRT;
              err_r      <= 1'b0;
              state_r    <= ST_SR_LAST;
            end
          end
          ST_SR_LAST: begin
            if ((n_r == 10'd0) || (tbl_step_r && (v_r > last_brt_r))) begin
              err_r   <= 1'b1;
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_SR_FIRST;
            end
          end
          ST_SR_FIRST: begin
            if (!tbl_step_r) begin
              last_brt_r <= rd_data_c;
            end
            if (rd_data_c < v_r) begin
              err_r   <= 1'b1;
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_SR_INIT;
            end
          end
          ST_SR_INIT: begin
            if (rd_data_c > v_r) begin
              err_r   <= 1'b1;
              state_r <= ST_FIN;
            end else begin
              l_r     <= '0;
              hi_r    <= n_r;
              state_r <= ST_SR_PROBE;
            end
          end
          ST_SR_PROBE: begin
            if (l_r < hi_r) begin
              m_r     <= m_c[8:0];
              state_r <= ST_SR_CMP;
            end else begin
              err_r   <= 1'b1;
              state_r <= ST_FIN;
            end
          end
          ST_SR_CMP: begin
            if (rd_data_c < v_r) begin
              l_r <= {1'b0, m_r} + 10'd1;
            end else begin
              hi_r <= {1'b0, m_r};
            end
            state_r <= ST_SR_PROBE;
          end
          ST_RD_LO: begin
            state_r <= ST_RD_UP;
          end
          ST_RD_UP: begin
            blo_r   <= mrsp.brt;
            lumlo_r <= mrsp.lum;
            state_r <= ST_RD_UP2;
          end
          ST_RD_UP2: begin
            bup_r      <= mrsp.brt;
            lumup_r    <= mrsp.lum;
            v_r        <= blo_r;
            n_r        <= ns_r;
            tbl_step_r <= 1'b1;
            ph_r       <= PH_SLO;
            state_r    <= ST_SR_LAST;
          end
          ST_MUL1: begin
            if (sup_r == slo_r) begin
              q_r     <= '0;
              state_r <= ST_SUM;
            end else begin
              p1_r    <= prod_c;
              state_r <= ST_MUL2;
            end
          end
          ST_MUL2: begin
            p2_r    <= p2_c;
            state_r <= ST_DIV_GO;
          end
          ST_DIV_GO: begin
            neg_r   <= p2_r[34] ^ den_c[10];
            state_r <= ST_DIV_WAIT;
          end
          ST_DIV_WAIT: begin
            if (drsp.done) begin
              q_r     <= q_c;
              state_r <= ST_SUM;
            end
          end
          ST_SUM: begin
            hund_r  <= clamp_c;
            state_r <= ST_FIN;
          end
          ST_FIN: begin
            if (!out_valid_r || out_ch.ready) begin
              out_valid_r <= 1'b1;
              out_err_r   <= err_r;
              out_idx_r   <= err_r ? 8'd0 : up_r;
              out_step_r  <= err_r ? 9'd0 : sq_r;
              out_lum_r   <= err_r ? 16'd0 : lumup_r;
              out_hund_r  <= err_r ? 23'd0 : hund_r;
              state_r     <= ST_IDLE;
            end
          end
          default: begin
            state_r <= ST_IDLE;
          end
        endcase
      end
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.error                = out_err_r;
  assign out_ch.lum_index            = out_idx_r;
  assign out_ch.pac_step             = out_step_r;
  assign out_ch.luminance            = out_lum_r;
  assign out_ch.luminance_hundredths = out_hund_r;

endmodule
